[src/bct_pkg.sv]
// Shared types, constants and backoff table for the cooldown table unit.
package bct_pkg;

  localparam int DEFAULT_NUM_CHANNELS = 16;
  localparam int QUEUE_DEPTH          = 2;

  localparam int CMD_W       = 3;
  localparam int KEY_W       = 4;
  localparam int KIND_W      = 3;
  localparam int RETRY_W     = 24;
  localparam int COUNT_W     = 16;
  localparam int TIME_W      = 32;
  localparam int INTERVAL_W  = 16;
  localparam int REMAIN_W    = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int EXP_W       = 3;

  localparam logic [CMD_W-1:0] CMD_FAIL    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUCCESS = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PROBE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

  localparam logic [KIND_W-1:0] KIND_RATE_LIMIT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_AUTH          = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BILLING       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TRANSIENT     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MODEL_MISSING = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT       = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE = 2'd1;

  localparam logic [TIME_W-1:0]     DECAY_RESET = 32'd86400;
  localparam logic [INTERVAL_W-1:0] PROBE_RESET = 16'd60;
  localparam logic [COUNT_W-1:0]    COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [TIME_W-1:0]     TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [EXP_W-1:0]      EXP_MAX     = 3'd4;

  localparam logic [31:0] RL_BASE    = 32'd60;
  localparam logic [31:0] RL_CAP     = 32'd3600;
  localparam logic [31:0] BILL_BASE  = 32'd18000;
  localparam logic [31:0] BILL_CAP   = 32'd86400;
  localparam logic [31:0] TMO_BASE   = 32'd30;
  localparam logic [31:0] TMO_CAP    = 32'd300;
  localparam logic [31:0] UNK_BASE   = 32'd60;
  localparam logic [31:0] UNK_CAP    = 32'd600;
  localparam logic [31:0] AUTH_FIXED = 32'd3600;

  typedef enum logic [2:0] {
    OP_FAIL,
    OP_SUCCESS,
    OP_QUERY,
    OP_PROBE,
    OP_CLEAR,
    OP_TICK
  } op_t;

  typedef enum logic {
    EX_IDLE,
    EX_EXEC
  } ex_state_t;

  typedef struct packed {
    op_t                op;
    logic               key_ok;
    logic [KEY_W-1:0]   key;
    logic [KIND_W-1:0]  kind;
    logic [RETRY_W-1:0] retry;
  } work_t;

  typedef struct packed {
    logic [TIME_W-1:0]     decay;
    logic [INTERVAL_W-1:0] probe_interval;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  last_fail;
    logic [TIME_W-1:0]  last_probe;
    logic [TIME_W-1:0]  cool_end;
  } entry_t;

  typedef struct packed {
    logic                in_cooldown;
    logic [REMAIN_W-1:0] remaining;
    logic [COUNT_W-1:0]  count;
    logic                granted;
  } result_t;

  function automatic logic [RETRY_W-1:0] scaled(input logic [31:0] base,
                                                input logic [31:0] cap,
                                                input logic [EXP_W-1:0] e);
    logic [31:0] v;
    case (e)
      3'd0:    v = base;
      3'd1:    v = base * 32'd5;
      3'd2:    v = base * 32'd25;
      3'd3:    v = base * 32'd125;
      default: v = base * 32'd625;
    endcase
    return (v < cap) ? v[RETRY_W-1:0] : cap[RETRY_W-1:0];
  endfunction

  function automatic logic [RETRY_W-1:0] backoff(input logic [KIND_W-1:0] kind,
                                                 input logic [EXP_W-1:0] e);
    logic [RETRY_W-1:0] v;
    case (kind)
      KIND_RATE_LIMIT:    v = scaled(RL_BASE, RL_CAP, e);
      KIND_AUTH:          v = AUTH_FIXED[RETRY_W-1:0];
      KIND_BILLING:       v = scaled(BILL_BASE, BILL_CAP, e);
      KIND_TRANSIENT:     v = scaled(RL_BASE, RL_CAP, e);
      KIND_MODEL_MISSING: v = '0;
      KIND_TIMEOUT:       v = scaled(TMO_BASE, TMO_CAP, e);
      default:            v = scaled(UNK_BASE, UNK_CAP, e);
    endcase
    return v;
  endfunction

endpackage

[src/bct_if.sv]
// Handshake interfaces for the command, result and configuration channels.
interface bct_req_if import bct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key_index;
  logic [KIND_W-1:0]  error_kind;
  logic [RETRY_W-1:0] retry_after;

  modport source (output valid, cmd, key_index, error_kind, retry_after, input ready);
  modport sink (input valid, cmd, key_index, error_kind, retry_after, output ready);
endinterface

interface bct_rsp_if import bct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                in_cooldown;
  logic [REMAIN_W-1:0] remaining_seconds;
  logic [COUNT_W-1:0]  fail_total;
  logic                probe_granted;

  modport source (output valid, in_cooldown, remaining_seconds, fail_total,
                  probe_granted, input ready);
  modport sink (input valid, in_cooldown, remaining_seconds, fail_total,
                probe_granted, output ready);
endinterface

interface bct_cfg_if import bct_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/bct_front.sv]
// Front end: takes command words, classifies them and holds the config registers.
module bct_front import bct_pkg::*; #(
  parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
  input  logic  clk,
  input  logic  rst,
  bct_req_if.sink req,
  bct_cfg_if.sink cfg,
  output cfg_t  cfg_regs,
  output logic  push_valid,
  input  logic  push_ready,
  output work_t push_word
);

  logic key_ok;
  op_t  op;

  always_comb begin
    key_ok = (32'(req.key_index) < 32'(NUM_CHANNELS));
    case (req.cmd)
      CMD_FAIL:    op = key_ok ? OP_FAIL : OP_QUERY;
      CMD_SUCCESS: op = key_ok ? OP_SUCCESS : OP_QUERY;
      CMD_QUERY:   op = OP_QUERY;
      CMD_PROBE:   op = key_ok ? OP_PROBE : OP_QUERY;
      CMD_CLEAR:   op = OP_CLEAR;
      CMD_TICK:    op = OP_TICK;
      default:     op = OP_QUERY;
    endcase
  end

  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  always_comb begin
    push_word.op     = op;
    push_word.key_ok = key_ok;
    push_word.key    = req.key_index;
    push_word.kind   = req.error_kind;
    push_word.retry  = req.retry_after;
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.decay          <= DECAY_RESET;
      cfg_regs.probe_interval <= PROBE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_DECAY: cfg_regs.decay          <= cfg.data;
        CFG_PROBE: cfg_regs.probe_interval <= cfg.data[INTERVAL_W-1:0];
        default:   ;
      endcase
    end
  end

endmodule

[src/bct_queue.sv]
// Short command queue between the front end and the execution unit.
module bct_queue import bct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_word,
  output logic  pop_valid,
  input  logic  pop,
  output work_t pop_word
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

[src/bct_exec.sv]
// Execution unit: entry read, update and write-back, time counter, result register.
module bct_exec import bct_pkg::*; #(
  parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg_regs,
  input  logic  pop_valid,
  input  work_t pop_word,
  output logic  pop,
  bct_rsp_if.source rsp
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  ex_state_t state;
  ex_state_t state_next;

  work_t                   cur;
  entry_t                  mem [NUM_CHANNELS];
  entry_t                  rd;
  entry_t                  wr;
  logic [NUM_CHANNELS-1:0] valid;
  logic [TIME_W-1:0]       now;
  logic [TIME_W-1:0]       now_inc;
  logic [TIME_W-1:0]       now_eff;

  logic                out_valid;
  result_t             out_word;
  result_t             res;
  logic                out_free;
  logic                commit;
  logic                mem_we;

  logic [IDX_W-1:0]    addr;
  logic                hit;
  logic [TIME_W-1:0]   since_fail;
  logic [TIME_W-1:0]   since_probe;
  logic                stale;
  logic [COUNT_W-1:0]  count_keep;
  logic [COUNT_W-1:0]  count_base;
  logic [COUNT_W-1:0]  count_new;
  logic [EXP_W-1:0]    exp_keep;
  logic [RETRY_W-1:0]  dur_keep;
  logic [RETRY_W-1:0]  dur_fresh;
  logic [RETRY_W-1:0]  dur;
  logic [TIME_W:0]     end_sum;
  logic [TIME_W-1:0]   fail_end;
  logic [TIME_W-1:0]   headroom;
  logic [REMAIN_W-1:0] fail_remain;
  logic                cooling_st;
  logic [TIME_W-1:0]   diff;
  logic [REMAIN_W-1:0] remain_st;
  logic                grant;

  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      EX_IDLE: if (pop_valid) state_next = EX_EXEC;
      EX_EXEC: if (out_free) state_next = EX_IDLE;
      default: state_next = EX_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    commit = 1'b0;
    case (state)
      EX_IDLE: pop    = pop_valid;
      EX_EXEC: commit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    addr    = IDX_W'(cur.key);
    hit     = cur.key_ok && valid[addr];
    now_eff = (cur.op == OP_TICK) ? now_inc : now;

    since_fail  = (now >= rd.last_fail) ? now - rd.last_fail : '0;
    since_probe = (now >= rd.last_probe) ? now - rd.last_probe : '0;

    count_keep = hit ? rd.count : '0;
    stale      = hit && (rd.count != '0) && (since_fail > cfg_regs.decay);
    count_base = stale ? '0 : count_keep;
    count_new  = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
    exp_keep   = (count_keep >= COUNT_W'(EXP_MAX)) ? EXP_MAX : count_keep[EXP_W-1:0];

    dur_keep  = (cur.retry != '0) ? cur.retry : backoff(cur.kind, exp_keep);
    dur_fresh = (cur.retry != '0) ? cur.retry : backoff(cur.kind, '0);
    dur       = stale ? dur_fresh : dur_keep;

    end_sum     = {1'b0, now} + {{(TIME_W + 1 - RETRY_W){1'b0}}, dur};
    fail_end    = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    headroom    = ~now;
    fail_remain = ({{(TIME_W - RETRY_W){1'b0}}, dur} <= headroom) ? dur
                                                                  : headroom[REMAIN_W-1:0];

    cooling_st = hit && (now_eff < rd.cool_end);
    diff       = rd.cool_end - now_eff;
    remain_st  = (diff[TIME_W-1:REMAIN_W] != '0) ? {REMAIN_W{1'b1}} : diff[REMAIN_W-1:0];
    grant      = hit && (now < rd.cool_end) &&
                 (since_probe >= TIME_W'(cfg_regs.probe_interval));

    res = '0;
    case (cur.op)
      OP_FAIL: begin
        res.in_cooldown = (fail_remain != '0);
        res.remaining   = fail_remain;
        res.count       = count_new;
      end
      OP_SUCCESS, OP_CLEAR: res = '0;
      OP_PROBE: begin
        res.in_cooldown = cooling_st;
        res.remaining   = cooling_st ? remain_st : '0;
        res.count       = count_keep;
        res.granted     = grant;
      end
      default: begin
        res.in_cooldown = cooling_st;
        res.remaining   = cooling_st ? remain_st : '0;
        res.count       = count_keep;
      end
    endcase

    wr = rd;
    case (cur.op)
      OP_FAIL: begin
        wr.count      = count_new;
        wr.kind       = cur.kind;
        wr.last_fail  = now;
        wr.last_probe = now;
        wr.cool_end   = fail_end;
      end
      OP_PROBE: wr.last_probe = now;
      default:  ;
    endcase
    mem_we = commit && ((cur.op == OP_FAIL) || ((cur.op == OP_PROBE) && grant));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_word;
      rd  <= mem[IDX_W'(pop_word.key)];
    end
    if (mem_we) begin
      mem[addr] <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      now     <= '0;
      now_inc <= TIME_W'(1);
    end else if (commit) begin
      case (cur.op)
        OP_FAIL:    valid[addr] <= 1'b1;
        OP_SUCCESS: valid[addr] <= 1'b0;
        OP_CLEAR:   valid       <= '0;
        OP_TICK: begin
          now     <= now_inc;
          now_inc <= (now_inc == TIME_MAX) ? now_inc : now_inc + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_word <= res;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.in_cooldown       = out_word.in_cooldown;
  assign rsp.remaining_seconds = out_word.remaining;
  assign rsp.fail_total        = out_word.count;
  assign rsp.probe_granted     = out_word.granted;

endmodule

[src/backoff_cooldown_table_unit.sv]
// Top level of the per-channel backoff cooldown table.
//
// Channels: req carries command words (cmd, key_index, error_kind, retry_after);
// rsp returns one result word per command (in_cooldown, remaining_seconds,
// fail_total, probe_granted), in command order. cfg writes the failure
// decay time (index 0) and the probe interval (index 1) and is always ready;
// write it only while no command is in flight.
// Flow: an accepted command waits in the queue; the execution unit then does a
// registered read of the channel entry, then update and write-back, and puts
// the result in the output register. It takes a new command only after the
// last result has entered that register. A two-entry queue lets req keep taking words
// while a result waits in the output register.
// Stall: while rsp.ready is low, the finished result holds, the execution unit
// waits, the queue fills and then req.ready drops.
// Reset: the table is empty, the seconds counter is zero and both config
// registers take their defaults; no clearing pass is needed.
module backoff_cooldown_table_unit import bct_pkg::*; #(
  parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
  input logic clk,
  input logic rst,
  bct_req_if.sink   req,
  bct_rsp_if.source rsp,
  bct_cfg_if.sink   cfg
);

  cfg_t  cfg_regs;
  logic  push_valid;
  logic  push_ready;
  work_t push_word;
  logic  pop_valid;
  logic  pop;
  work_t pop_word;

  bct_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .cfg_regs  (cfg_regs),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_word (push_word)
  );

  bct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_word (push_word),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_word  (pop_word)
  );

  bct_exec #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .pop_valid(pop_valid),
    .pop_word (pop_word),
    .pop      (pop),
    .rsp      (rsp)
  );

endmodule

[verif/backoff_cooldown_table_unit_tb.sv]
// Self-checking testbench: directed table, random phases and a full-rate tail run.
module backoff_cooldown_table_unit_tb import bct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_KEYS = 16;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int TAIL_ITEMS = 30;
  localparam int SCRIPT_LEN = 24;
  localparam int RANDOM_PHASE = 4;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SEVEN = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd2;

  localparam logic [31:0] DECAY_PLAN [PHASES] = '{32'd0, 32'd3, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd12};
  localparam logic [31:0] PROBE_PLAN [PHASES] = '{32'd0, 32'd2, 32'd65535, 32'd5, 32'd0, 32'd1};

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [KIND_W-1:0]  kind;
    logic [RETRY_W-1:0] retry;
    logic               fixed;
    result_t            want;
  } step_row_t;

  localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_QUERY,   4'd0,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b0, 24'd0,        16'd0, 1'b0}},
    '{CMD_FAIL,    4'd0,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b1, 24'd60,       16'd1, 1'b0}},
    '{CMD_FAIL,    4'd0,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b1, 24'd300,      16'd2, 1'b0}},
    '{CMD_PROBE,   4'd0,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b1, 24'd300,      16'd2, 1'b0}},
    '{CMD_FAIL,    4'd1,  KIND_AUTH,          24'd0,        1'b1, '{1'b1, 24'd3600,     16'd1, 1'b0}},
    '{CMD_FAIL,    4'd2,  KIND_MODEL_MISSING, 24'd0,        1'b1, '{1'b0, 24'd0,        16'd1, 1'b0}},
    '{CMD_FAIL,    4'd3,  KIND_BILLING,       24'd0,        1'b1, '{1'b1, 24'd18000,    16'd1, 1'b0}},
    '{CMD_FAIL,    4'd4,  KIND_TIMEOUT,       24'd0,        1'b1, '{1'b1, 24'd30,       16'd1, 1'b0}},
    '{CMD_FAIL,    4'd5,  KIND_UNKNOWN,       24'd0,        1'b1, '{1'b1, 24'd60,       16'd1, 1'b0}},
    '{CMD_FAIL,    4'd6,  KIND_SEVEN,         24'd0,        1'b1, '{1'b1, 24'd60,       16'd1, 1'b0}},
    '{CMD_FAIL,    4'd7,  KIND_TRANSIENT,     24'hFFFFFF,   1'b1, '{1'b1, 24'hFFFFFF,   16'd1, 1'b0}},
    '{CMD_SPARE6,  4'd7,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b1, 24'hFFFFFF,   16'd1, 1'b0}},
    '{CMD_SPARE7,  4'd15, KIND_SEVEN,         24'hFFFFFF,   1'b1, '{1'b0, 24'd0,        16'd0, 1'b0}},
    '{CMD_TICK,    4'd7,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b1, 24'hFFFFFE,   16'd1, 1'b0}},
    '{CMD_SUCCESS, 4'd7,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b0, 24'd0,        16'd0, 1'b0}},
    '{CMD_QUERY,   4'd7,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b0, 24'd0,        16'd0, 1'b0}},
    '{CMD_FAIL,    4'd4,  KIND_TIMEOUT,       24'd0,        1'b1, '{1'b1, 24'd150,      16'd2, 1'b0}},
    '{CMD_FAIL,    4'd4,  KIND_TIMEOUT,       24'd0,        1'b1, '{1'b1, 24'd300,      16'd3, 1'b0}},
    '{CMD_FAIL,    4'd3,  KIND_BILLING,       24'd0,        1'b1, '{1'b1, 24'd86400,    16'd2, 1'b0}},
    '{CMD_PROBE,   4'd8,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b0, 24'd0,        16'd0, 1'b0}},
    '{CMD_PROBE,   4'd2,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b0, 24'd0,        16'd1, 1'b0}},
    '{CMD_FAIL,    4'd0,  KIND_TRANSIENT,     24'd5,        1'b0, '{1'b0, 24'd0,        16'd0, 1'b0}},
    '{CMD_CLEAR,   4'd0,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b0, 24'd0,        16'd0, 1'b0}},
    '{CMD_QUERY,   4'd1,  KIND_RATE_LIMIT,    24'd0,        1'b1, '{1'b0, 24'd0,        16'd0, 1'b0}}
  };

  logic clk;
  logic rst = 1'b1;

  bct_req_if req ();
  bct_rsp_if rsp ();
  bct_cfg_if cfg ();

  backoff_cooldown_table_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  logic [TIME_W-1:0]     clock_s;
  logic [TIME_W-1:0]     decay_s;
  logic [INTERVAL_W-1:0] probe_gap_s;
  logic [NUM_KEYS-1:0]   chan_live;
  logic [COUNT_W-1:0]    chan_fails [NUM_KEYS];
  logic [KIND_W-1:0]     chan_kind [NUM_KEYS];
  logic [TIME_W-1:0]     chan_fail_at [NUM_KEYS];
  logic [TIME_W-1:0]     chan_probe_at [NUM_KEYS];
  logic [TIME_W-1:0]     chan_end [NUM_KEYS];

  result_t pending_status [$];
  result_t status_head;
  int errors = 0;
  bit calm = 1'b0;
  bit src_busy = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] backoff_for(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] n);
    logic [31:0] base;
    logic [31:0] cap;
    logic [31:0] v;
    case (kind)
      KIND_RATE_LIMIT, KIND_TRANSIENT: begin
        base = 32'd60;
        cap = 32'd3600;
      end
      KIND_AUTH: return 32'd3600;
      KIND_BILLING: begin
        base = 32'd18000;
        cap = 32'd86400;
      end
      KIND_MODEL_MISSING: return 32'd0;
      KIND_TIMEOUT: begin
        base = 32'd30;
        cap = 32'd300;
      end
      default: begin
        base = 32'd60;
        cap = 32'd600;
      end
    endcase
    v = base;
    for (int i = 1; i < n && i < 5; i++) v = v * 32'd5;
    return (v < cap) ? v : cap;
  endfunction

  function automatic logic [31:0] since(logic [TIME_W-1:0] t);
    return (clock_s >= t) ? clock_s - t : 32'd0;
  endfunction

  function automatic result_t apply_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                            logic [KIND_W-1:0] kind, logic [RETRY_W-1:0] retry);
    result_t r;
    logic [31:0] dur;
    logic [32:0] sum;
    logic [31:0] left;
    r = '0;
    case (cmd)
      CMD_CLEAR: chan_live = '0;
      CMD_TICK: if (clock_s != TIME_MAX) clock_s = clock_s + 32'd1;
      CMD_FAIL: begin
        if (!chan_live[key]) begin
          chan_live[key] = 1'b1;
          chan_fails[key] = '0;
        end else if (chan_fails[key] != 0 && since(chan_fail_at[key]) > decay_s) begin
          chan_fails[key] = '0;
        end
        if (chan_fails[key] != COUNT_MAX) chan_fails[key] = chan_fails[key] + 16'd1;
        chan_kind[key] = kind;
        chan_fail_at[key] = clock_s;
        chan_probe_at[key] = clock_s;
        dur = (retry != 0) ? 32'(retry) : backoff_for(kind, chan_fails[key]);
        sum = {1'b0, clock_s} + {1'b0, dur};
        chan_end[key] = sum[32] ? TIME_MAX : sum[31:0];
      end
      CMD_SUCCESS: chan_live[key] = 1'b0;
      CMD_PROBE: begin
        if (chan_live[key] && clock_s < chan_end[key] &&
            since(chan_probe_at[key]) >= 32'(probe_gap_s)) begin
          chan_probe_at[key] = clock_s;
          r.granted = 1'b1;
        end
      end
      default: ;
    endcase
    if (chan_live[key]) begin
      r.count = chan_fails[key];
      if (clock_s < chan_end[key]) begin
        r.in_cooldown = 1'b1;
        left = chan_end[key] - clock_s;
        r.remaining = (left > 32'hFF_FFFF) ? '1 : left[REMAIN_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing pending", $time);
      end else begin
        status_head = pending_status.pop_front();
        check_field("in_cooldown", 32'(status_head.in_cooldown), 32'(rsp.in_cooldown));
        check_field("remaining_seconds", 32'(status_head.remaining), 32'(rsp.remaining_seconds));
        check_field("fail_total", 32'(status_head.count), 32'(rsp.fail_total));
        check_field("probe_granted", 32'(status_head.granted), 32'(rsp.probe_granted));
      end
    end
  end

  initial begin
    rsp.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic hold_off();
    if (!calm && src_busy && $urandom_range(0, 2) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [KIND_W-1:0] kind, input logic [RETRY_W-1:0] retry,
                           input logic fixed, input result_t want);
    result_t got;
    hold_off();
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.key_index <= key;
    req.error_kind <= kind;
    req.retry_after <= retry;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    got = apply_command(cmd, key, kind, retry);
    pending_status.push_back(fixed ? want : got);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      CFG_DECAY: decay_s = data;
      CFG_PROBE: probe_gap_s = data[INTERVAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] decay, input logic [31:0] probe_word,
                              input bit poke_spare);
    cfg_write(CFG_DECAY, decay);
    cfg_write(CFG_PROBE, probe_word);
    if (poke_spare) cfg_write(CFG_SPARE, $urandom);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [CMD_W-1:0]   c;
    logic [KEY_W-1:0]   k;
    logic [KIND_W-1:0]  kd;
    logic [RETRY_W-1:0] ra;
    logic [KEY_W-1:0]   hot;
    logic [31:0]        dw;
    logic [31:0]        pw;
    int pick;
    int run;
    int n;

    req.valid = 1'b0;
    req.cmd = CMD_QUERY;
    req.key_index = '0;
    req.error_kind = KIND_RATE_LIMIT;
    req.retry_after = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_DECAY;
    cfg.data = '0;

    clock_s = '0;
    decay_s = DECAY_RESET;
    probe_gap_s = PROBE_RESET;
    chan_live = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      chan_fails[i] = '0;
      chan_kind[i] = '0;
      chan_fail_at[i] = '0;
      chan_probe_at[i] = '0;
      chan_end[i] = '0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i])
      send_word(SCRIPT[i].cmd, SCRIPT[i].key, SCRIPT[i].kind, SCRIPT[i].retry,
                SCRIPT[i].fixed, SCRIPT[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      dw = (p == RANDOM_PHASE) ? $urandom : DECAY_PLAN[p];
      pw = (p == RANDOM_PHASE) ? $urandom : PROBE_PLAN[p];
      program_regs(dw, pw, p == 2);
      hot = 4'($urandom_range(0, 12));
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) src_busy = ~src_busy;
        pick = $urandom_range(0, 99);
        if (pick < 30) c = CMD_FAIL;
        else if (pick < 38) c = CMD_SUCCESS;
        else if (pick < 48) c = CMD_QUERY;
        else if (pick < 68) c = CMD_PROBE;
        else if (pick < 70) c = CMD_CLEAR;
        else if (pick < 95) c = CMD_TICK;
        else c = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
        k = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : hot + 4'($urandom_range(0, 3));
        kd = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
          0, 1: ra = '0;
          2: ra = 24'($urandom_range(1, 120));
          default: ra = 24'($urandom);
        endcase
        run = (c == CMD_TICK && $urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : 1;
        repeat (run) begin
          send_word(c, k, kd, ra, 1'b0, '0);
          n++;
        end
      end
    end

    // finish with a full-rate run on one channel
    drain();
    calm = 1'b1;
    program_regs(32'hFFFF_FFFF, 32'd0, 1'b0);
    repeat (TAIL_ITEMS)
      send_word(CMD_FAIL, 4'd9, 3'($urandom_range(0, 7)), 24'($urandom_range(0, 40)), 1'b0, '0);
    send_word(CMD_PROBE, 4'd9, KIND_RATE_LIMIT, '0, 1'b0, '0);
    send_word(CMD_QUERY, 4'd9, KIND_RATE_LIMIT, '0, 1'b0, '0);

    req.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/bct_pkg.sv
src/bct_if.sv
src/bct_front.sv
src/bct_queue.sv
src/bct_exec.sv
src/backoff_cooldown_table_unit.sv
verif/backoff_cooldown_table_unit_tb.sv
